/* rtl/core/dwpfm_pkg.sv */
package dwpfm_pkg;

    localparam int TICK_BITS_DEF  = 32;
    localparam int FREQ_FRAC_DEF  = 12;

    localparam int US_PER_S       = 1000000;
    localparam int US_W           = 20;
    localparam int US_PER_MS      = 1000;

    localparam int FREQ_W         = 32;
    localparam int W_W            = 17;
    localparam int PPR_W          = 16;
    localparam int TMO_W          = 23;
    localparam int LIMIT_W        = 33;
    localparam int CFG_W          = 23;
    localparam int CFG_IDX_W      = 2;
    localparam int EMA_P_W        = 49;
    localparam int EMA_S_W        = 50;
    localparam int EMA_SHIFT      = 16;
    localparam int PROD_W         = 64;

    // 2*pi in Q3.28, velocity divisor is the pulse count per turn << 28
    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam int VEL_SHIFT      = 28;
    localparam int VNUM_W         = 36;

    localparam logic [W_W-1:0]     W_ONE       = 17'd65536;
    localparam logic [W_W-1:0]     W_RST       = 17'd32768;
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = 33'd500000;

    localparam logic       OP_EDGE  = 1'b0;
    localparam logic [1:0] LVL_HIGH = 2'd1;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ON  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_W   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PPR        = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE,
        ST_FDIV,
        ST_EMA_A,
        ST_EMA_B,
        ST_EMA_W,
        ST_VIS,
        ST_VMUL_L,
        ST_VSTART_L,
        ST_VDIV_L,
        ST_VMUL_R,
        ST_VSTART_R,
        ST_VDIV_R,
        ST_OUT
    } dwpfm_state_t;

    typedef struct packed {
        logic load_in;
        logic edge_step;
        logic fdiv_start;
        logic store_raw;
        logic ema_a;
        logic ema_b;
        logic ema_store;
        logic vis_load;
        logic vel_mul;
        logic vel_start;
        logic vel_store;
        logic side;
        logic out_load;
    } dwpfm_cmd_t;

    typedef struct packed {
        logic rise;
        logic edge_ok;
        logic div_done;
        logic smooth_on;
        logic out_free;
    } dwpfm_sts_t;

endpackage

/* rtl/core/dwpfm_div.sv */
module dwpfm_div #(
    parameter int DVD_W = 36,
    parameter int DVS_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dvd,
    input  logic [DVS_W-1:0] dvs,
    output logic [DVD_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0] rem_reg,  rem_next;
    logic [DVD_W-1:0] quo_reg,  quo_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        diff     = trial - {1'b0, dvs_reg};
        rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dvd;
            dvs_reg <= dvs;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

/* rtl/core/dwpfm_ctrl.sv */
module dwpfm_ctrl
    import dwpfm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dwpfm_sts_t sts,
    output dwpfm_cmd_t cmd
);

    dwpfm_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EDGE;
            end
            ST_EDGE: begin
                if (sts.rise && sts.edge_ok) state_next = ST_FDIV;
                else                         state_next = ST_VIS;
            end
            ST_FDIV: begin
                if (sts.div_done) state_next = sts.smooth_on ? ST_EMA_A : ST_VIS;
            end
            ST_EMA_A:    state_next = ST_EMA_B;
            ST_EMA_B:    state_next = ST_EMA_W;
            ST_EMA_W:    state_next = ST_VIS;
            ST_VIS:      state_next = ST_VMUL_L;
            ST_VMUL_L:   state_next = ST_VSTART_L;
            ST_VSTART_L: state_next = ST_VDIV_L;
            ST_VDIV_L: begin
                if (sts.div_done) state_next = ST_VMUL_R;
            end
            ST_VMUL_R:   state_next = ST_VSTART_R;
            ST_VSTART_R: state_next = ST_VDIV_R;
            ST_VDIV_R: begin
                if (sts.div_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (sts.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.load_in = s_tvalid;
            end
            ST_EDGE: begin
                cmd.edge_step  = sts.rise;
                cmd.fdiv_start = sts.rise && sts.edge_ok;
            end
            ST_FDIV:     cmd.store_raw = sts.div_done && !sts.smooth_on;
            ST_EMA_A:    cmd.ema_a     = 1'b1;
            ST_EMA_B:    cmd.ema_b     = 1'b1;
            ST_EMA_W:    cmd.ema_store = 1'b1;
            ST_VIS:      cmd.vis_load  = 1'b1;
            ST_VMUL_L:   cmd.vel_mul   = 1'b1;
            ST_VSTART_L: cmd.vel_start = 1'b1;
            ST_VDIV_L:   cmd.vel_store = sts.div_done;
            ST_VMUL_R: begin
                cmd.vel_mul = 1'b1;
                cmd.side    = 1'b1;
            end
            ST_VSTART_R: begin
                cmd.vel_start = 1'b1;
                cmd.side      = 1'b1;
            end
            ST_VDIV_R: begin
                cmd.vel_store = sts.div_done;
                cmd.side      = 1'b1;
            end
            ST_OUT:      cmd.out_load  = sts.out_free;
            default: begin
                cmd      = '0;
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/dwpfm_dp.sv */
module dwpfm_dp
    import dwpfm_pkg::*;
#(
    parameter int TICK_BITS      = TICK_BITS_DEF,
    parameter int FREQ_FRAC_BITS = FREQ_FRAC_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_operation,
    input  logic [31:0]          in_tick_us,
    input  logic                 in_channel,
    input  logic [1:0]           in_level,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [127:0]         m_data,
    input  dwpfm_cmd_t           cmd,
    output dwpfm_sts_t           sts
);

    localparam int ONE_W  = US_W + FREQ_FRAC_BITS;
    localparam int NUM_W  = (ONE_W > TICK_BITS ? ONE_W : TICK_BITS) + 1;
    localparam int DVD_W  = NUM_W > VNUM_W ? NUM_W : VNUM_W;
    localparam int DVS_W  = TICK_BITS > PPR_W ? TICK_BITS : PPR_W;
    localparam int CMP_W  = TICK_BITS > LIMIT_W ? TICK_BITS : LIMIT_W;
    localparam logic [NUM_W-1:0] ONE_Q = NUM_W'(US_PER_S) << FREQ_FRAC_BITS;

    logic                 op_reg;
    logic [TICK_BITS-1:0] tick_reg;
    logic                 chan_reg;
    logic [1:0]           level_reg;

    logic [LIMIT_W-1:0]   limit_reg;
    logic                 smooth_on_reg;
    logic [W_W-1:0]       weight_reg;
    logic [PPR_W-1:0]     ppr_reg;

    logic [TICK_BITS-1:0] last_reg [2];
    logic [FREQ_W-1:0]    freq_reg [2];
    logic [FREQ_W-1:0]    vis_reg  [2];
    logic [FREQ_W-1:0]    rad_reg  [2];
    logic [PROD_W-1:0]    prod_reg;
    logic [EMA_P_W-1:0]   hold_reg;
    logic [127:0]         out_reg;
    logic                 valid_reg;

    logic [TICK_BITS-1:0] prev;
    logic [TICK_BITS-1:0] delta;
    logic [NUM_W-1:0]     fnum;
    logic                 div_start;
    logic [DVD_W-1:0]     div_dvd;
    logic [DVS_W-1:0]     div_dvs;
    logic [DVD_W-1:0]     div_quo;
    logic                 div_done;
    logic [FREQ_W-1:0]    q_sat;
    logic [W_W-1:0]       w_sat;
    logic [W_W-1:0]       w_inv;
    logic [FREQ_W-1:0]    mul_a;
    logic [FREQ_W-1:0]    mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [EMA_S_W-1:0]   ema_sum;
    logic [EMA_S_W-EMA_SHIFT-1:0] ema_q;
    logic [FREQ_W-1:0]    ema_sat;
    logic [PROD_W-1:0]    vsum;
    logic [VNUM_W-1:0]    vnum;
    logic [TICK_BITS-1:0] age      [2];
    logic [FREQ_W-1:0]    vis_next [2];

    always_comb begin
        prev  = last_reg[chan_reg];
        delta = tick_reg - prev;
        fnum  = ONE_Q + NUM_W'(delta >> 1);

        q_sat = (|div_quo[DVD_W-1:FREQ_W]) ? '1 : div_quo[FREQ_W-1:0];

        w_sat = (weight_reg > W_ONE) ? W_ONE : weight_reg;
        w_inv = W_ONE - w_sat;

        // one shared multiplier: the two smoothing terms, then f * 2pi
        if (cmd.ema_a) begin
            mul_a = FREQ_W'(w_sat);
            mul_b = q_sat;
        end else if (cmd.ema_b) begin
            mul_a = FREQ_W'(w_inv);
            mul_b = freq_reg[chan_reg];
        end else begin
            mul_a = vis_reg[cmd.side];
            mul_b = FREQ_W'(TWO_PI_Q28);
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

        ema_sum = EMA_S_W'(hold_reg) + EMA_S_W'(prod_reg[EMA_P_W-1:0]) + EMA_S_W'(32768);
        ema_q   = ema_sum[EMA_S_W-1:EMA_SHIFT];
        ema_sat = (|ema_q[EMA_S_W-EMA_SHIFT-1:FREQ_W]) ? '1 : ema_q[FREQ_W-1:0];

        // rounding half of the divisor, then drop the 2^28 common factor
        vsum = prod_reg + (PROD_W'(ppr_reg) << (VEL_SHIFT - 1));
        vnum = vsum[PROD_W-1:VEL_SHIFT];

        div_start = cmd.fdiv_start | cmd.vel_start;
        div_dvd   = cmd.fdiv_start ? DVD_W'(fnum)  : DVD_W'(vnum);
        div_dvs   = cmd.fdiv_start ? DVS_W'(delta) : DVS_W'(ppr_reg);

        // age wraps at the tick width before it is compared with the limit
        for (int i = 0; i < 2; i++) begin
            age[i] = tick_reg - last_reg[i];
            if (last_reg[i] == '0 || CMP_W'(age[i]) > CMP_W'(limit_reg)) begin
                vis_next[i] = '0;
            end else begin
                vis_next[i] = freq_reg[i];
            end
        end
    end

    dwpfm_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dvd     (div_dvd),
        .dvs     (div_dvs),
        .quo     (div_quo),
        .done    (div_done)
    );

    // configuration and measurement state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg     <= LIMIT_RST;
            smooth_on_reg <= 1'b0;
            weight_reg    <= W_RST;
            ppr_reg       <= '0;
            last_reg[0]   <= '0;
            last_reg[1]   <= '0;
            freq_reg[0]   <= '0;
            freq_reg[1]   <= '0;
            valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_TIMEOUT_MS: limit_reg     <= LIMIT_W'(cfg_wdata[TMO_W-1:0]) *
                                                     LIMIT_W'(US_PER_MS);
                    REG_SMOOTH_ON:  smooth_on_reg <= cfg_wdata[0];
                    REG_SMOOTH_W:   weight_reg    <= cfg_wdata[W_W-1:0];
                    REG_PPR:        ppr_reg       <= cfg_wdata[PPR_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (cmd.edge_step) last_reg[chan_reg] <= tick_reg;
            if (cmd.store_raw) freq_reg[chan_reg] <= q_sat;
            if (cmd.ema_store) freq_reg[chan_reg] <= ema_sat;
            if (cmd.out_load) begin
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg    <= in_operation;
            tick_reg  <= TICK_BITS'(in_tick_us);
            chan_reg  <= in_channel;
            level_reg <= in_level;
        end
        if (cmd.ema_a || cmd.ema_b || cmd.vel_mul) prod_reg <= mul_p;
        if (cmd.ema_b) hold_reg <= prod_reg[EMA_P_W-1:0];
        if (cmd.vis_load) begin
            vis_reg[0] <= vis_next[0];
            vis_reg[1] <= vis_next[1];
        end
        if (cmd.vel_store) rad_reg[cmd.side] <= (ppr_reg == '0) ? '0 : q_sat;
        if (cmd.out_load) out_reg <= {rad_reg[1], rad_reg[0], vis_reg[1], vis_reg[0]};
    end

    always_comb begin
        sts.rise      = (op_reg == OP_EDGE) && (level_reg == LVL_HIGH);
        sts.edge_ok   = (prev != '0) && (delta != '0);
        sts.div_done  = div_done;
        sts.smooth_on = smooth_on_reg;
        sts.out_free  = !valid_reg || m_tready;
    end

    assign m_tvalid = valid_reg;
    assign m_data   = out_reg;

endmodule

/* rtl/core/dual_wheel_period_frequency_meter_core.sv */
// Two-channel wheel tachometer.
// Input items arrive on the s_ stream: each carries a microsecond timestamp,
// and an edge item also names a wheel and a pin level. A high level on an
// edge item stores the timestamp and, from the period to the previous edge,
// updates that wheel's frequency (raw or exponentially smoothed). Every item
// returns one result item on the m_ stream with both frequencies and both
// angular velocities, Q20.12, with a wheel reading zero when it is stale.
// Configuration is written through cfg_we / cfg_index / cfg_wdata; the user
// must write it only while the block is idle, which the block itself does not
// enforce. There is no read-back. Items are handled one at a time; the block
// returns to idle before it accepts the next item. The shared restoring
// divider is 36 bits wide at the default parameters. It runs once for the
// frequency and once per wheel for the velocity, one bit per cycle.
// A finished result waits in the output register while the next item is
// accepted; if the receiver stalls, the block holds the result and stops
// before loading the next one. Reset clears both wheels' stored edges and
// frequencies and restores the register defaults.
module dual_wheel_period_frequency_meter_core
    import dwpfm_pkg::*;
#(
    parameter int TICK_BITS      = TICK_BITS_DEF,
    parameter int FREQ_FRAC_BITS = FREQ_FRAC_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // tick_us[31:0], level[33:32], zero pad
    input  logic [1:0]           s_tuser,   // operation[0], channel[1]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [127:0]         m_tdata,   // left_hz, right_hz, left_rad_s, right_rad_s
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    dwpfm_cmd_t cmd;
    dwpfm_sts_t sts;

    dwpfm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dwpfm_dp #(
        .TICK_BITS      (TICK_BITS),
        .FREQ_FRAC_BITS (FREQ_FRAC_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_operation (s_tuser[0]),
        .in_tick_us   (s_tdata[31:0]),
        .in_channel   (s_tuser[1]),
        .in_level     (s_tdata[33:32]),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_data       (m_tdata),
        .cmd          (cmd),
        .sts          (sts)
    );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import dwpfm_pkg::*;

    localparam logic       OP_SAMPLE    = 1'b1;
    localparam logic [1:0] LVL_LOW      = 2'd0;
    localparam logic [1:0] LVL_TIMEOUT  = 2'd2;
    localparam logic [1:0] LVL_WATCHDOG = 2'd3;
    localparam logic       CH_LEFT      = 1'b0;
    localparam logic       CH_RIGHT     = 1'b1;
    localparam int         CYCLE_LIMIT  = 2000000;
    localparam int         ITEMS_PER_PHASE = 240;

    typedef struct packed {
        logic [31:0] right_rad_s;
        logic [31:0] left_rad_s;
        logic [31:0] right_hz;
        logic [31:0] left_hz;
    } reading_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [39:0]          s_tdata = '0;     // tick_us[31:0], level[33:32], zero pad
    logic [1:0]           s_tuser = '0;     // operation[0], channel[1]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [127:0]         m_tdata;          // left_hz, right_hz, left_rad_s, right_rad_s
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // predictor copy of the wheel state and the registers
    logic [31:0] wheel_last_tick [2];
    logic [31:0] wheel_freq [2];
    logic [63:0] cfg_timeout_ms;
    logic        cfg_smooth_on;
    logic [63:0] cfg_smooth_weight;
    logic [63:0] cfg_ppr;

    reading_t    pending_readings [$];
    reading_t    got_reading;
    reading_t    want_reading;
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          cycle_count = 0;
    logic [31:0] tick_now = '0;

    dual_wheel_period_frequency_meter_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] sat32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void record_edge(logic ch, logic [31:0] tick);
        logic [31:0] prev;
        logic [31:0] period;
        logic [63:0] hz;
        logic [63:0] w;
        prev = wheel_last_tick[ch];
        wheel_last_tick[ch] = tick;
        if (prev == 0) return;
        period = tick - prev;
        if (period == 0) return;
        hz = sat32(((64'd1000000 << FREQ_FRAC_DEF) + 64'(period) / 2) / 64'(period));
        if (cfg_smooth_on) begin
            w = (cfg_smooth_weight > 64'd65536) ? 64'd65536 : cfg_smooth_weight;
            hz = sat32((w * hz + (64'd65536 - w) * 64'(wheel_freq[ch]) + 64'd32768) >> 16);
        end
        wheel_freq[ch] = hz[31:0];
    endfunction

    function automatic logic [31:0] visible_hz(logic ch, logic [31:0] tick);
        logic [31:0] age;
        age = tick - wheel_last_tick[ch];
        if (wheel_last_tick[ch] == 0) return 32'd0;
        if (64'(age) > cfg_timeout_ms * 64'd1000) return 32'd0;
        return wheel_freq[ch];
    endfunction

    function automatic logic [31:0] hz_to_rad_s(logic [31:0] hz);
        logic [63:0] den;
        if (cfg_ppr == 0) return 32'd0;
        den = cfg_ppr << 28;
        return sat32((64'(hz) * 64'(TWO_PI_Q28) + den / 2) / den);
    endfunction

    function automatic reading_t predict_reading(logic op, logic [31:0] tick, logic ch,
                                                 logic [1:0] lvl);
        reading_t r;
        if (op == OP_EDGE && lvl == LVL_HIGH) record_edge(ch, tick);
        r.left_hz     = visible_hz(CH_LEFT, tick);
        r.right_hz    = visible_hz(CH_RIGHT, tick);
        r.left_rad_s  = hz_to_rad_s(r.left_hz);
        r.right_rad_s = hz_to_rad_s(r.right_hz);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
    endtask

    // result checker and receiver stall
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_tvalid && m_tready) begin
            got_reading = m_tdata;
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected item, left_hz", 32'd0, got_reading.left_hz);
            end else begin
                want_reading = pending_readings.pop_front();
                if (got_reading.left_hz != want_reading.left_hz)
                    report_mismatch("left_hz", want_reading.left_hz, got_reading.left_hz);
                if (got_reading.right_hz != want_reading.right_hz)
                    report_mismatch("right_hz", want_reading.right_hz, got_reading.right_hz);
                if (got_reading.left_rad_s != want_reading.left_rad_s)
                    report_mismatch("left_rad_s", want_reading.left_rad_s,
                                    got_reading.left_rad_s);
                if (got_reading.right_rad_s != want_reading.right_rad_s)
                    report_mismatch("right_rad_s", want_reading.right_rad_s,
                                    got_reading.right_rad_s);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [31:0] tick, logic ch, logic [1:0] lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, lvl, tick};
        s_tuser  <= {ch, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_readings.push_back(predict_reading(op, tick, ch, lvl));
    endtask

    // hold the sender until every expected item has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_readings.size() != 0);
    endtask

    task automatic configure(logic [63:0] tmo_ms, logic smooth, logic [63:0] weight,
                             logic [63:0] ppr);
        cfg_we <= 1'b1;
        cfg_index <= REG_TIMEOUT_MS;
        cfg_wdata <= CFG_W'(tmo_ms);
        @(posedge aclk);
        cfg_index <= REG_SMOOTH_ON;
        cfg_wdata <= CFG_W'(smooth);
        @(posedge aclk);
        cfg_index <= REG_SMOOTH_W;
        cfg_wdata <= CFG_W'(weight);
        @(posedge aclk);
        cfg_index <= REG_PPR;
        cfg_wdata <= CFG_W'(ppr);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_timeout_ms    = tmo_ms & 64'h7F_FFFF;
        cfg_smooth_on     = smooth;
        cfg_smooth_weight = weight & 64'h1_FFFF;
        cfg_ppr           = ppr & 64'hFFFF;
    endtask

    // missing edges, edge at time zero, repeated timestamp, ignored levels, wrap, timeout
    task automatic test_edge_rules();
        configure(64'd500, 1'b0, 64'd32768, 64'd0);
        send_item(OP_SAMPLE, 32'd0, CH_LEFT, LVL_LOW);
        send_item(OP_EDGE, 32'd0, CH_LEFT, LVL_HIGH);
        send_item(OP_EDGE, 32'd1000, CH_LEFT, LVL_HIGH);
        send_item(OP_EDGE, 32'd1000, CH_LEFT, LVL_HIGH);
        send_item(OP_EDGE, 32'd2000, CH_LEFT, LVL_HIGH);
        send_item(OP_EDGE, 32'd2500, CH_LEFT, LVL_LOW);
        send_item(OP_EDGE, 32'd2600, CH_LEFT, LVL_TIMEOUT);
        send_item(OP_EDGE, 32'd2700, CH_LEFT, LVL_WATCHDOG);
        send_item(OP_SAMPLE, 32'd3000, CH_RIGHT, LVL_HIGH);
        send_item(OP_EDGE, 32'hFFFF_FFF0, CH_RIGHT, LVL_HIGH);
        send_item(OP_EDGE, 32'h0000_0010, CH_RIGHT, LVL_HIGH);
        send_item(OP_EDGE, 32'h0000_0011, CH_RIGHT, LVL_HIGH);
        send_item(OP_SAMPLE, 32'h11 + 32'd500000, CH_LEFT, LVL_LOW);
        send_item(OP_SAMPLE, 32'h11 + 32'd500001, CH_LEFT, LVL_LOW);
        wait_drained();
    endtask

    // timeout just under the 32-bit tick range, near-full smoothing weight, one pulse per turn saturates velocity
    task automatic test_limits();
        configure(64'd4294967, 1'b1, 64'd65535, 64'd1);
        send_item(OP_EDGE, 32'h1000_0000, CH_LEFT, LVL_HIGH);
        send_item(OP_EDGE, 32'h1000_0001, CH_LEFT, LVL_HIGH);
        send_item(OP_EDGE, 32'h1000_0002, CH_RIGHT, LVL_HIGH);
        send_item(OP_SAMPLE, 32'hFFFF_FFFF, CH_RIGHT, LVL_WATCHDOG);
        send_item(OP_SAMPLE, 32'h1000_0001 + 32'd4294967001, CH_LEFT, LVL_LOW);
        send_item(OP_EDGE, 32'd0, CH_LEFT, LVL_HIGH);
        send_item(OP_EDGE, 32'd5, CH_LEFT, LVL_HIGH);
        wait_drained();
    endtask

    // wheel-like traffic on a running clock, with some raw noise mixed in
    task automatic test_random_traffic(int count);
        int          pick;
        logic [31:0] step;
        logic        op;
        logic [1:0]  lvl;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(199) == 0) wait_drained();
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(1'($urandom), ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom),
                          1'($urandom), 2'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 3)       step = 32'd0;
                else if (pick < 50) step = $urandom_range(1, 4000);
                else if (pick < 80) step = $urandom_range(4000, 60000);
                else if (pick < 93) step = $urandom_range(60000, 600000);
                else                step = $urandom;
                tick_now = tick_now + step;
                op  = ($urandom_range(99) < 15) ? OP_SAMPLE : OP_EDGE;
                lvl = ($urandom_range(99) < 80) ? LVL_HIGH : 2'($urandom);
                send_item(op, tick_now, 1'($urandom), lvl);
            end
        end
        wait_drained();
    endtask

    initial begin
        wheel_last_tick = '{32'd0, 32'd0};
        wheel_freq      = '{32'd0, 32'd0};
        cfg_timeout_ms    = 64'd500;
        cfg_smooth_on     = 1'b0;
        cfg_smooth_weight = 64'd32768;
        cfg_ppr           = 64'd0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 29;
        recv_idle_pct = 46;
        test_edge_rules();
        test_limits();
        configure(64'd20, 1'b1, 64'd16384, 64'd1);
        test_random_traffic(ITEMS_PER_PHASE);
        configure(64'd0, 1'b0, 64'd32768, 64'd65535);
        test_random_traffic(ITEMS_PER_PHASE);

        send_idle_pct = 46;
        recv_idle_pct = 29;
        configure(64'd4294967, 1'b1, 64'd65536, 64'd360);
        test_random_traffic(ITEMS_PER_PHASE);
        configure(64'd1000, 1'b1, 64'd0, 64'd20);
        test_random_traffic(ITEMS_PER_PHASE / 2);
        configure(64'd500, 1'b1, 64'd131071, 64'd4096);
        test_random_traffic(ITEMS_PER_PHASE / 2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure(64'd8388607, 1'b1, 64'd1, 64'd2);
        test_random_traffic(ITEMS_PER_PHASE);
        configure(64'd50, 1'b0, 64'd40000, 64'd1024);
        test_random_traffic(ITEMS_PER_PHASE);

        // let any stray item show up before the verdict
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
